[sv/rcrc_pkg.sv]
// Package for the reflected multi-width CRC unit.
// Holds mode codes, polynomials, width masks and their selection functions.
// No dependencies.
`default_nettype none

package rcrc_pkg;

  localparam int unsigned CrcW  = 32;
  localparam int unsigned ByteW = 8;
  localparam int unsigned ModeW = 2;

  typedef enum logic [ModeW-1:0] {
    CRC_MODE_8  = 2'd0,
    CRC_MODE_16 = 2'd1,
    CRC_MODE_32 = 2'd2
  } crc_mode_e;

  localparam logic [CrcW-1:0] POLY_CRC8  = 32'h0000_00E0;
  localparam logic [CrcW-1:0] POLY_CRC16 = 32'h0000_A001;
  localparam logic [CrcW-1:0] POLY_CRC32 = 32'hEDB8_8320;
  localparam logic [CrcW-1:0] MASK_CRC8  = 32'h0000_00FF;
  localparam logic [CrcW-1:0] MASK_CRC16 = 32'h0000_FFFF;
  localparam logic [CrcW-1:0] MASK_CRC32 = 32'hFFFF_FFFF;
  localparam logic [CrcW-1:0] CRC_INIT   = MASK_CRC32;

  localparam logic [ModeW-1:0] CRC_MODE_RESET = CRC_MODE_32;

  function automatic logic [CrcW-1:0] width_mask(input logic [ModeW-1:0] mode);
    logic [CrcW-1:0] m;
    case (mode)
      CRC_MODE_8:  m = MASK_CRC8;
      CRC_MODE_16: m = MASK_CRC16;
      default:     m = MASK_CRC32;
    endcase
    return m;
  endfunction

  function automatic logic [CrcW-1:0] width_poly(input logic [ModeW-1:0] mode);
    logic [CrcW-1:0] p;
    case (mode)
      CRC_MODE_8:  p = POLY_CRC8;
      CRC_MODE_16: p = POLY_CRC16;
      default:     p = POLY_CRC32;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

[sv/reflected_crc_multi_width_unit.sv]
// A byte beat is registered in the input stage; a last byte's result is then registered in the result stage.
// Throughput: one byte per cycle unless a last byte holds; the update is one registered pass.
// A result register parts the sides; only a last byte holds while a result waits.
// Reset: mode CRC-32, running CRC all ones, input and result stages empty.
// Top level of the reflected multi-width CRC unit; uses rcrc_pkg, rcrc_update.
`default_nettype none

module reflected_crc_multi_width_unit (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [rcrc_pkg::ModeW-1:0] cfg_wdata_i,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [rcrc_pkg::ByteW-1:0] data_byte_i,
  input  wire logic                       last_byte_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic      [rcrc_pkg::CrcW-1:0]  crc_value_o
);
  import rcrc_pkg::*;

  logic [ModeW-1:0] mode_q;
  logic             in_valid_q;
  logic [ByteW-1:0] data_q;
  logic             last_q;
  logic [CrcW-1:0]  crc_q;
  logic             out_valid_q;
  logic [CrcW-1:0]  crc_value_q;

  logic [CrcW-1:0]  crc_next;
  logic [CrcW-1:0]  crc_final;
  logic             out_free;
  logic             advance;

  rcrc_update u_update (
    .mode_i  (mode_q),
    .crc_i   (crc_q),
    .data_i  (data_q),
    .crc_o   (crc_next),
    .final_o (crc_final)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = in_valid_q && (!last_q || out_free);
  assign in_ready_o = !in_valid_q || advance;

  // mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= CRC_MODE_RESET;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  // input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= data_byte_i;
      last_q <= last_byte_i;
    end
  end

  // running CRC: reload on the last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= CRC_INIT;
    end else if (advance) begin
      crc_q <= last_q ? CRC_INIT : crc_next;
    end
  end

  // result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance && last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && last_q) begin
      crc_value_q <= crc_final;
    end
  end

  assign out_valid_o = out_valid_q;
  assign crc_value_o = crc_value_q;

`ifndef SYNTH
  a_reload_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && last_q |=> crc_q == CRC_INIT)
    else $error("running CRC not reloaded after last byte");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(crc_value_q))
    else $error("pending result lost or overwritten");

  a_beat_captured: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> in_valid_q)
    else $error("accepted byte beat not held in input stage");
`endif

endmodule

`default_nettype wire

[sv/rcrc_update.sv]
// One-byte reflected CRC update, eight shift/xor steps unrolled.
// Also forms the complemented, width-masked final value. Uses rcrc_pkg.
`default_nettype none

module rcrc_update (
  input  wire logic [rcrc_pkg::ModeW-1:0] mode_i,
  input  wire logic [rcrc_pkg::CrcW-1:0]  crc_i,
  input  wire logic [rcrc_pkg::ByteW-1:0] data_i,
  output logic      [rcrc_pkg::CrcW-1:0]  crc_o,
  output logic      [rcrc_pkg::CrcW-1:0]  final_o
);
  import rcrc_pkg::*;

  logic [CrcW-1:0] mask;
  logic [CrcW-1:0] poly;
  logic [CrcW-1:0] c;

  always_comb begin
    mask = width_mask(mode_i);
    poly = width_poly(mode_i);
    c    = (crc_i & mask) ^ {{(CrcW-ByteW){1'b0}}, data_i};
    for (int k = 0; k < ByteW; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ poly;
      end else begin
        c = c >> 1;
      end
    end
    crc_o   = c & mask;
    final_o = ~crc_o & mask;
  end

endmodule

`default_nettype wire
